// ===== rtl/core/exp_damping_evaluator_assert.svh =====
// assertion macros shared by the checker of the exponential damping evaluator
// no dependencies; included by edv_checker.sv
`ifndef EXP_DAMPING_EVALUATOR_ASSERT_SVH
`define EXP_DAMPING_EVALUATOR_ASSERT_SVH

// same-cycle implication
`define EDV_ASSERT_IMPLY(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define EDV_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/edv_pkg.sv =====
// constants, types and the exponent table of the exponential damping evaluator
// no dependencies; used by every module of the block
package edv_pkg;

    localparam int FRAC_BITS        = 16;
    localparam int TABLE_ADDR_BITS  = 10;
    localparam int DATA_W           = 32;
    localparam int CFG_IDX_W        = 2;

    localparam int TBL_N            = 1 << TABLE_ADDR_BITS;
    localparam int TBL_IDX_W        = TABLE_ADDR_BITS + 1;
    localparam int MANT_BITS        = 30;
    localparam int FRAC_ALL         = FRAC_BITS + MANT_BITS;
    localparam int REM_BITS         = FRAC_ALL - TABLE_ADDR_BITS;
    localparam int INTERP_BITS      = 24;
    localparam int T_LIMIT_SHIFT    = 2 * FRAC_BITS + 7;
    localparam int TERM_LIMIT_SHIFT = 34;

    localparam int D_W      = DATA_W + 1;
    localparam int T_W      = DATA_W + D_W;
    localparam int TQ_W     = T_LIMIT_SHIFT - FRAC_BITS + 2;
    localparam int LOG2E_W  = 32;
    localparam int UW_W     = TQ_W + LOG2E_W - 1;
    localparam int N_W      = UW_W - FRAC_ALL;
    localparam int MANT_W   = MANT_BITS + 2;
    localparam int M_W      = MANT_BITS + 1;
    localparam int DIFF_W   = DATA_W - TABLE_ADDR_BITS;
    localparam int P_W      = DATA_W + M_W;
    localparam int SH_W     = N_W + 1;
    localparam int SHAMT_W  = $clog2(P_W);
    localparam int WIDE_W   = P_W + TERM_LIMIT_SHIFT + 1;
    localparam int TERM_W   = TERM_LIMIT_SHIFT + 2;
    localparam int Y_W      = TERM_W + 1;

    localparam int PREP_STAGES  = 4;
    localparam int EXP2_STAGES  = 3;
    localparam int SCALE_STAGES = 4;
    localparam int NUM_STAGES   = PREP_STAGES + EXP2_STAGES + SCALE_STAGES;

    localparam logic signed [LOG2E_W-1:0] LOG2E_Q30 = 32'sd1549082005;
    localparam logic [DATA_W-1:0] ONE_FIX = DATA_W'(64'd1 << FRAC_BITS);

    typedef enum logic [CFG_IDX_W-1:0]
    {
        CFG_AMPLITUDE = 2'd0,
        CFG_RATE      = 2'd1,
        CFG_OFFSET    = 2'd2
    } cfg_index_t;

    typedef logic [MANT_W-1:0] pow2_tab_t [0:TBL_N];

    // rounded integer square root
    function automatic logic [63:0] isqrt_round(input logic [63:0] x_in);
        logic [63:0] x;
        logic [63:0] r;
        logic [63:0] b;
        int k;
        x = x_in;
        r = '0;
        b = 64'h4000_0000_0000_0000;
        for (k = 0; k < 32; k++)
        begin
            if (x >= r + b)
            begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end
            else
            begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        if (x > r)
        begin
            r = r + 64'd1;
        end
        return r;
    endfunction

    // 2^(i / TBL_N) in q30, built from rounded products of repeated roots of two
    function automatic pow2_tab_t build_pow2_tab();
        pow2_tab_t tab;
        logic [63:0] roots [0:TABLE_ADDR_BITS];
        logic [63:0] v;
        int i;
        int b;
        roots[0] = 64'd1 << 31;
        for (i = 1; i <= TABLE_ADDR_BITS; i++)
        begin
            roots[i] = isqrt_round(roots[i - 1] << 30);
        end
        for (i = 0; i < TBL_N; i++)
        begin
            v = 64'd1 << 30;
            for (b = 0; b < TABLE_ADDR_BITS; b++)
            begin
                if (((i >> b) & 1) != 0)
                begin
                    v = (v * roots[TABLE_ADDR_BITS - b] + (64'd1 << 29)) >> 30;
                end
            end
            tab[i] = MANT_W'(v);
        end
        tab[TBL_N] = MANT_W'(64'd1 << 31);
        return tab;
    endfunction

    localparam pow2_tab_t POW2_TAB = build_pow2_tab();

endpackage

// ===== rtl/core/exp_damping_evaluator.sv =====
// throughput: one item per cycle unless stalled, set by the eleven-stage pipeline with a valid bit per stage
// a stalled output holds only the stages behind it that are full; bubbles still fill
// reset clears all valid bits and loads amplitude 1.0, rate 1.0, offset 0; no clearing pass
// top level: config registers, pipeline control; depends on edv_pkg, edv_prep, edv_exp2,
// edv_scale
module exp_damping_evaluator
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [edv_pkg::DATA_W-1:0]        s_axis_tdata,   // x_value
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [edv_pkg::DATA_W-1:0]        m_axis_tdata,   // y_value
    output logic [0:0]                        m_axis_tuser,   // saturated
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [edv_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [edv_pkg::DATA_W-1:0]        cfg_data
);
    import edv_pkg::*;

    localparam int EXP2_BASE  = PREP_STAGES;
    localparam int SCALE_BASE = PREP_STAGES + EXP2_STAGES;

    logic signed [DATA_W-1:0] amplitude_reg;
    logic signed [DATA_W-1:0] rate_reg;
    logic signed [DATA_W-1:0] offset_reg;
    logic [NUM_STAGES-1:0]    valid_reg, valid_next;
    logic [NUM_STAGES-1:0]    load;
    logic signed [UW_W-1:0]   uw;
    logic [M_W-1:0]           m;
    logic signed [N_W-1:0]    n;
    logic signed [DATA_W-1:0] y_value;
    logic                     saturated;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            amplitude_reg <= ONE_FIX;
            rate_reg      <= ONE_FIX;
            offset_reg    <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_AMPLITUDE: amplitude_reg <= cfg_data;
                CFG_RATE:      rate_reg      <= cfg_data;
                CFG_OFFSET:    offset_reg    <= cfg_data;
                default:       ;
            endcase
        end
    end

    // a stage loads when it or any stage ahead of it is empty, or the output is taken
    always_comb
    begin
        for (int i = 0; i < NUM_STAGES; i++)
        begin
            load[i] = m_axis_tready || ((~valid_reg & (NUM_STAGES'('1) << i)) != '0);
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (load[0])
        begin
            valid_next[0] = s_axis_tvalid;
        end
        for (int i = 1; i < NUM_STAGES; i++)
        begin
            if (load[i])
            begin
                valid_next[i] = valid_reg[i - 1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    edv_prep u_prep
    (
        .clk     (clk),
        .load    (load[PREP_STAGES-1:0]),
        .x_value ($signed(s_axis_tdata)),
        .rate    (rate_reg),
        .offset  (offset_reg),
        .uw      (uw)
    );

    edv_exp2 u_exp2
    (
        .clk  (clk),
        .load (load[EXP2_BASE +: EXP2_STAGES]),
        .uw   (uw),
        .m    (m),
        .n    (n)
    );

    edv_scale u_scale
    (
        .clk       (clk),
        .load      (load[SCALE_BASE +: SCALE_STAGES]),
        .amplitude (amplitude_reg),
        .m         (m),
        .n         (n),
        .y_value   (y_value),
        .saturated (saturated)
    );

    assign s_axis_tready   = load[0];
    assign m_axis_tvalid   = valid_reg[NUM_STAGES-1];
    assign m_axis_tdata    = y_value;
    assign m_axis_tuser[0] = saturated;

endmodule

// ===== rtl/core/edv_prep.sv =====
// exponent argument stages: offset subtract, rate multiply, clamp, log2(e) scaling
// depends on edv_pkg
module edv_prep
(
    input  logic                               clk,
    input  logic [edv_pkg::PREP_STAGES-1:0]    load,
    input  logic signed [edv_pkg::DATA_W-1:0]  x_value,
    input  logic signed [edv_pkg::DATA_W-1:0]  rate,
    input  logic signed [edv_pkg::DATA_W-1:0]  offset,
    output logic signed [edv_pkg::UW_W-1:0]    uw
);
    import edv_pkg::*;

    localparam logic signed [T_W-1:0] T_LIMIT = T_W'(1) << T_LIMIT_SHIFT;

    logic signed [D_W-1:0]  d_reg, d_next;
    logic signed [T_W-1:0]  t_reg, t_next;
    logic signed [T_W-1:0]  t_clamp;
    logic signed [TQ_W-1:0] tq_reg, tq_next;
    logic signed [UW_W-1:0] uw_reg, uw_next;

    assign d_next = D_W'(x_value) - D_W'(offset);
    assign t_next = T_W'(rate) * T_W'(d_reg);

    always_comb
    begin
        t_clamp = t_reg;
        if (t_reg > T_LIMIT)
        begin
            t_clamp = T_LIMIT;
        end
        else if (t_reg < -T_LIMIT)
        begin
            t_clamp = -T_LIMIT;
        end
        tq_next = t_clamp[FRAC_BITS +: TQ_W];
    end

    assign uw_next = UW_W'(tq_reg) * UW_W'(LOG2E_Q30);

    always_ff @(posedge clk)
    begin
        if (load[0])
        begin
            d_reg <= d_next;
        end
        if (load[1])
        begin
            t_reg <= t_next;
        end
        if (load[2])
        begin
            tq_reg <= tq_next;
        end
        if (load[3])
        begin
            uw_reg <= uw_next;
        end
    end

    assign uw = uw_reg;

endmodule

// ===== rtl/core/edv_exp2.sv =====
// fractional power of two: table lookup and linear interpolation into a q30 mantissa
// depends on edv_pkg
module edv_exp2
(
    input  logic                               clk,
    input  logic [edv_pkg::EXP2_STAGES-1:0]    load,
    input  logic signed [edv_pkg::UW_W-1:0]    uw,
    output logic [edv_pkg::M_W-1:0]            m,
    output logic signed [edv_pkg::N_W-1:0]     n
);
    import edv_pkg::*;

    localparam int PROD_W = DIFF_W + INTERP_BITS;

    logic [TBL_IDX_W-1:0]    idx_lo;
    logic [TBL_IDX_W-1:0]    idx_hi;
    logic [MANT_W-1:0]       lo_reg;
    logic [MANT_W-1:0]       hi_reg;
    logic [INTERP_BITS-1:0]  rem_reg;
    logic signed [N_W-1:0]   n4_reg;
    logic [DIFF_W-1:0]       diff;
    logic [PROD_W-1:0]       prod;
    logic [DIFF_W-1:0]       interp_reg, interp_next;
    logic [M_W-1:0]          lo5_reg;
    logic signed [N_W-1:0]   n5_reg;
    logic [M_W-1:0]          m_reg, m_next;
    logic signed [N_W-1:0]   n6_reg;

    assign idx_lo = {1'b0, uw[FRAC_ALL-1 -: TABLE_ADDR_BITS]};
    assign idx_hi = idx_lo + TBL_IDX_W'(1);

    // table read, registered
    always_ff @(posedge clk)
    begin
        if (load[0])
        begin
            lo_reg  <= POW2_TAB[idx_lo];
            hi_reg  <= POW2_TAB[idx_hi];
            rem_reg <= uw[REM_BITS-1 -: INTERP_BITS];
            n4_reg  <= uw[UW_W-1 -: N_W];
        end
    end

    assign diff        = DIFF_W'(hi_reg - lo_reg);
    assign prod        = PROD_W'(diff) * PROD_W'(rem_reg);
    assign interp_next = prod[INTERP_BITS +: DIFF_W];
    assign m_next      = lo5_reg + M_W'(interp_reg);

    always_ff @(posedge clk)
    begin
        if (load[1])
        begin
            interp_reg <= interp_next;
            lo5_reg    <= lo_reg[M_W-1:0];
            n5_reg     <= n4_reg;
        end
        if (load[2])
        begin
            m_reg  <= m_next;
            n6_reg <= n5_reg;
        end
    end

    assign m = m_reg;
    assign n = n6_reg;

endmodule

// ===== rtl/core/edv_scale.sv =====
// amplitude scaling, power-of-two shift with limiting, final add and clipping
// depends on edv_pkg
module edv_scale
(
    input  logic                               clk,
    input  logic [edv_pkg::SCALE_STAGES-1:0]   load,
    input  logic signed [edv_pkg::DATA_W-1:0]  amplitude,
    input  logic [edv_pkg::M_W-1:0]            m,
    input  logic signed [edv_pkg::N_W-1:0]     n,
    output logic signed [edv_pkg::DATA_W-1:0]  y_value,
    output logic                               saturated
);
    import edv_pkg::*;

    localparam logic signed [WIDE_W-1:0] WIDE_LIMIT = WIDE_W'(1) << TERM_LIMIT_SHIFT;
    localparam logic signed [TERM_W-1:0] TERM_MAX   = TERM_W'(1) << TERM_LIMIT_SHIFT;
    localparam logic signed [Y_W-1:0]    Y_MAX      = (Y_W'(1) <<< (DATA_W - 1)) - Y_W'(1);
    localparam logic signed [Y_W-1:0]    Y_MIN      = -(Y_W'(1) <<< (DATA_W - 1));

    logic signed [P_W-1:0]    p_reg, p_next;
    logic signed [N_W-1:0]    n7_reg;
    logic signed [SH_W-1:0]   sh;
    logic signed [SH_W-1:0]   neg_sh;
    logic signed [WIDE_W-1:0] wide_reg, wide_next;
    logic                     big_reg, big_next;
    logic signed [TERM_W-1:0] term_reg, term_next;
    logic signed [Y_W-1:0]    y_sum;
    logic signed [DATA_W-1:0] y_reg, y_next;
    logic                     sat_reg, sat_next;

    assign p_next = P_W'(amplitude) * P_W'($signed({1'b0, m}));

    assign sh     = SH_W'(n7_reg) - SH_W'(MANT_BITS);
    assign neg_sh = -sh;

    always_comb
    begin
        big_next  = 1'b0;
        wide_next = WIDE_W'(p_reg);
        if (!sh[SH_W-1])
        begin
            if (sh > SH_W'(TERM_LIMIT_SHIFT))
            begin
                big_next = (p_reg != '0);
            end
            else
            begin
                wide_next = WIDE_W'(p_reg) <<< sh[SHAMT_W-1:0];
            end
        end
        else
        begin
            if (neg_sh > SH_W'(P_W - 1))
            begin
                wide_next = p_reg[P_W-1] ? '1 : '0;
            end
            else
            begin
                wide_next = WIDE_W'(p_reg >>> neg_sh[SHAMT_W-1:0]);
            end
        end
    end

    // limit the term to +-2^34, which keeps every clipped sum clipped
    always_comb
    begin
        if (big_reg)
        begin
            term_next = wide_reg[WIDE_W-1] ? -TERM_MAX : TERM_MAX;
        end
        else if (wide_reg > WIDE_LIMIT)
        begin
            term_next = TERM_MAX;
        end
        else if (wide_reg < -WIDE_LIMIT)
        begin
            term_next = -TERM_MAX;
        end
        else
        begin
            term_next = wide_reg[TERM_W-1:0];
        end
    end

    assign y_sum = Y_W'(amplitude) + Y_W'(term_reg);

    always_comb
    begin
        y_next   = y_sum[DATA_W-1:0];
        sat_next = 1'b0;
        if (y_sum > Y_MAX)
        begin
            y_next   = Y_MAX[DATA_W-1:0];
            sat_next = 1'b1;
        end
        else if (y_sum < Y_MIN)
        begin
            y_next   = Y_MIN[DATA_W-1:0];
            sat_next = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load[0])
        begin
            p_reg  <= p_next;
            n7_reg <= n;
        end
        if (load[1])
        begin
            wide_reg <= wide_next;
            big_reg  <= big_next;
        end
        if (load[2])
        begin
            term_reg <= term_next;
        end
        if (load[3])
        begin
            y_reg   <= y_next;
            sat_reg <= sat_next;
        end
    end

    assign y_value   = y_reg;
    assign saturated = sat_reg;

endmodule

// ===== rtl/core/edv_checker.sv =====
// port-level checks of the exponential damping evaluator, bound to the top level
// depends on exp_damping_evaluator_assert.svh and exp_damping_evaluator
`include "exp_damping_evaluator_assert.svh"

module edv_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic [0:0]  m_axis_tuser
);

    // output side holds a stalled item
    `EDV_ASSERT_NEXT(a_out_valid_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "output item dropped while stalled")
    `EDV_ASSERT_NEXT(a_out_data_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata) && $stable(m_axis_tuser), "output item changed while stalled")

    // input backpressure only comes from a stalled full output
    `EDV_ASSERT_IMPLY(a_in_stall_cause, clk, rst_n, !s_axis_tready, m_axis_tvalid && !m_axis_tready, "input stalled without output backpressure")

    // a clipped result sits at one of the range limits
    `EDV_ASSERT_IMPLY(a_sat_value, clk, rst_n, m_axis_tvalid && m_axis_tuser[0], m_axis_tdata == 32'h7fff_ffff || m_axis_tdata == 32'h8000_0000, "saturated item not at a range limit")

endmodule

bind exp_damping_evaluator edv_checker u_edv_checker (.*);

// ===== tb/sv/tb_exp_damping_evaluator.sv =====
`timescale 1ns / 100ps
// testbench for exp_damping_evaluator: streams x arguments, predicts y = a*(1 + e^(k*(x-b)))
// bit for bit and compares every result item; depends on edv_pkg and the rtl of the block
module tb_exp_damping_evaluator;

    import edv_pkg::*;

    localparam int     CYCLE_LIMIT    = 1000000;
    localparam int     DRAIN_CYCLES   = 16;
    localparam int     EXP_ADDR_BITS  = 10;
    localparam int     EXP_TABLE_N    = 1 << EXP_ADDR_BITS;
    localparam int     Q_FRAC         = 16;
    localparam int     MANT_Q         = 30;
    localparam int     U_FRAC         = Q_FRAC + MANT_Q;
    localparam int     IDX_SHIFT      = U_FRAC - EXP_ADDR_BITS;
    localparam int     WEIGHT_BITS    = 24;
    localparam int     WEIGHT_SHIFT   = IDX_SHIFT - WEIGHT_BITS;
    localparam int     TERM_CAP_SHIFT = 34;
    localparam longint LOG2E_SCALED   = 64'sd1549082005;
    localparam longint T_CLAMP        = 64'sd1 << (2 * Q_FRAC + 7);
    localparam longint TERM_CAP       = 64'sd1 << TERM_CAP_SHIFT;
    localparam longint Y_MAX          = 64'sd2147483647;
    localparam longint Y_MIN          = -64'sd2147483648;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    localparam logic [31:0] Q_ONE     = 32'h0001_0000;
    localparam logic [31:0] Q_NEG_ONE = 32'hFFFF_0000;
    localparam logic [31:0] Q_MAX     = 32'h7FFF_FFFF;
    localparam logic [31:0] Q_MIN     = 32'h8000_0000;

    typedef struct packed
    {
        logic [31:0] x;
        logic [31:0] y;
        logic        sat;
    } damping_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [DATA_W-1:0]     s_axis_tdata = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [DATA_W-1:0]     m_axis_tdata;
    logic [0:0]            m_axis_tuser;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [DATA_W-1:0]     cfg_data = '0;

    logic signed [31:0] amp_q = 32'sh0001_0000;
    logic signed [31:0] rate_q = 32'sh0001_0000;
    logic signed [31:0] offset_q = 32'sh0000_0000;
    longint             exp2_frac [0:EXP_TABLE_N];
    damping_t           expected_damping [$];
    int                 mismatch_count = 0;
    int                 cycle_count = 0;
    int                 hold_left = 0;
    logic               steady_flow = 1'b0;

    exp_damping_evaluator dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic logic [63:0] sqrt_rounded(input logic [63:0] v);
        logic [63:0] rest;
        logic [63:0] root;
        logic [63:0] bitv;
        rest = v;
        root = '0;
        bitv = 64'd1 << 62;
        while (bitv > rest)
        begin
            bitv = bitv >> 2;
        end
        while (bitv != 0)
        begin
            if (rest >= root + bitv)
            begin
                rest = rest - (root + bitv);
                root = (root >> 1) + bitv;
            end
            else
            begin
                root = root >> 1;
            end
            bitv = bitv >> 2;
        end
        if (rest > root)
        begin
            root = root + 64'd1;
        end
        return root;
    endfunction

    // 2^(i/1024) in q30 as rounded products of repeated square roots of two
    function automatic void build_exp2_table();
        logic [63:0] roots [0:EXP_ADDR_BITS];
        logic [63:0] v;
        int i;
        int b;
        roots[0] = 64'd1 << 31;
        for (i = 1; i <= EXP_ADDR_BITS; i++)
        begin
            roots[i] = sqrt_rounded(roots[i - 1] << 30);
        end
        for (i = 0; i < EXP_TABLE_N; i++)
        begin
            v = 64'd1 << 30;
            for (b = 0; b < EXP_ADDR_BITS; b++)
            begin
                if (i[b])
                begin
                    v = (v * roots[EXP_ADDR_BITS - b] + (64'd1 << 29)) >> 30;
                end
            end
            exp2_frac[i] = longint'(v);
        end
        exp2_frac[EXP_TABLE_N] = 64'sd1 << 31;
    endfunction

    function automatic void predict_damping(input logic signed [31:0] x_in,
                                            output logic [31:0] y_out,
                                            output logic sat_out);
        longint d;
        longint t;
        longint tq;
        longint uw;
        longint n;
        longint frac;
        longint rem;
        longint m;
        longint p;
        longint shift;
        longint lim;
        longint term;
        longint y;
        int     idx;
        d = longint'(x_in) - longint'(offset_q);
        t = longint'(rate_q) * d;
        if (t > T_CLAMP)
        begin
            t = T_CLAMP;
        end
        else if (t < -T_CLAMP)
        begin
            t = -T_CLAMP;
        end
        tq = t >>> Q_FRAC;
        uw = tq * LOG2E_SCALED;
        n = uw >>> U_FRAC;
        frac = uw & ((64'sd1 << U_FRAC) - 1);
        idx = int'(frac >> IDX_SHIFT);
        rem = (frac & ((64'sd1 << IDX_SHIFT) - 1)) >> WEIGHT_SHIFT;
        m = exp2_frac[idx] + (((exp2_frac[idx + 1] - exp2_frac[idx]) * rem) >> WEIGHT_BITS);
        p = longint'(amp_q) * m;
        shift = n - MANT_Q;
        if (p == 0)
        begin
            term = 0;
        end
        else if (shift >= 0)
        begin
            if (shift > TERM_CAP_SHIFT)
            begin
                term = (p > 0) ? TERM_CAP : -TERM_CAP;
            end
            else
            begin
                lim = TERM_CAP >>> shift;
                if (p > lim)
                begin
                    term = TERM_CAP;
                end
                else if (p < -lim)
                begin
                    term = -TERM_CAP;
                end
                else
                begin
                    term = p <<< shift;
                end
            end
        end
        else if (-shift >= 63)
        begin
            term = (p < 0) ? -64'sd1 : 64'sd0;
        end
        else
        begin
            term = p >>> (-shift);
        end
        y = longint'(amp_q) + term;
        sat_out = 1'b0;
        if (y > Y_MAX)
        begin
            y = Y_MAX;
            sat_out = 1'b1;
        end
        else if (y < Y_MIN)
        begin
            y = Y_MIN;
            sat_out = 1'b1;
        end
        y_out = y[31:0];
    endfunction

    function automatic int pick_gap();
        int r;
        if (steady_flow)
        begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 65)
        begin
            return 0;
        end
        if (r < 93)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [31:0] signed_span(input logic [31:0] span);
        logic [31:0] v;
        v = $urandom_range(0, span);
        return $urandom_range(0, 1) ? -v : v;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (mismatch_count < 40)
        begin
            $display("mismatch: %s got %h expected %h", what, got, want);
        end
        mismatch_count++;
    endtask

    task automatic check_damping(input logic [31:0] y_got, input logic sat_got);
        damping_t want;
        if (expected_damping.size() == 0)
        begin
            report_mismatch("result item with none pending", y_got, '0);
            return;
        end
        want = expected_damping.pop_front();
        if (y_got !== want.y)
        begin
            report_mismatch($sformatf("y_value for x=%h", want.x), y_got, want.y);
        end
        if (sat_got !== want.sat)
        begin
            report_mismatch($sformatf("saturated for x=%h", want.x), 32'(sat_got),
                            32'(want.sat));
        end
    endtask

    // result sink with random back-pressure
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                check_damping(m_axis_tdata, m_axis_tuser[0]);
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                hold_left = pick_gap();
                m_axis_tready <= (hold_left == 0);
            end
        end
    end

    task automatic send_x(input logic [31:0] x);
        damping_t item;
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= x;
        do @(posedge clk); while (!s_axis_tready);
        item.x = x;
        predict_damping(x, item.y, item.sat);
        expected_damping.push_back(item);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
        case (idx)
            CFG_AMPLITUDE: amp_q = value;
            CFG_RATE:      rate_q = value;
            CFG_OFFSET:    offset_q = value;
            default:       ;
        endcase
    endtask

    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (expected_damping.size() != 0)
        begin
            @(posedge clk);
        end
        @(posedge clk);
    endtask

    task automatic test_default_response();
        send_x(32'h0000_0000);
        send_x(Q_ONE);
        send_x(Q_NEG_ONE);
        send_x(32'h0009_0000);
        send_x(32'h000A_0000);
        send_x(32'h000B_0000);
        send_x(Q_MAX);
        send_x(Q_MIN);
        settle();
    endtask

    task automatic test_zero_amplitude();
        write_register(CFG_AMPLITUDE, 32'h0000_0000);
        send_x(32'h0000_0000);
        send_x(Q_MAX);
        send_x(Q_MIN);
        settle();
    endtask

    task automatic test_negative_tail();
        write_register(CFG_AMPLITUDE, Q_NEG_ONE);
        send_x(Q_MIN);
        send_x(32'h000A_0000);
        send_x(Q_MAX);
        settle();
    endtask

    task automatic test_register_extremes();
        write_register(CFG_AMPLITUDE, Q_MAX);
        write_register(CFG_RATE, Q_MIN);
        write_register(CFG_OFFSET, Q_MAX);
        send_x(Q_MIN);
        send_x(Q_MAX);
        send_x(32'h0000_0000);
        settle();
        write_register(CFG_AMPLITUDE, Q_MIN);
        write_register(CFG_RATE, Q_MAX);
        write_register(CFG_OFFSET, Q_MIN);
        send_x(Q_MAX);
        send_x(Q_MIN);
        settle();
        write_register(CFG_RATE, 32'h0000_0000);
        send_x($urandom);
        settle();
    endtask

    task automatic test_unused_index();
        write_register(CFG_AMPLITUDE, Q_ONE);
        write_register(CFG_RATE, Q_ONE);
        write_register(CFG_OFFSET, 32'h0000_0000);
        write_register(CFG_SPARE, $urandom);
        send_x(Q_ONE);
        send_x(32'h0000_0000);
        settle();
    endtask

    function automatic logic [31:0] pick_amplitude();
        case ($urandom_range(0, 7))
            0:       return $urandom;
            1:       return 32'h0000_0000;
            2:       return signed_span(32'h0001_0000);
            default: return signed_span(32'h0040_0000);
        endcase
    endfunction

    function automatic logic [31:0] pick_rate();
        case ($urandom_range(0, 5))
            0:       return $urandom;
            1:       return 32'h0000_0000;
            default: return signed_span(32'h0004_0000);
        endcase
    endfunction

    // mostly arguments whose exponent lands in a useful range, the rest anywhere or at corner values
    function automatic logic [31:0] pick_x();
        longint mag;
        longint span;
        longint d;
        case ($urandom_range(0, 9))
            0, 1:
            begin
                return $urandom;
            end
            2:
            begin
                case ($urandom_range(0, 3))
                    0:       return Q_MIN;
                    1:       return Q_MAX;
                    2:       return 32'h0000_0000;
                    default: return offset_q;
                endcase
            end
            default:
            begin
                mag = (rate_q < 0) ? -longint'(rate_q) : longint'(rate_q);
                if (mag == 0)
                begin
                    return $urandom;
                end
                span = (64'sd24 << 32) / mag;
                if (span > 64'sh7FFF_FFFF)
                begin
                    span = 64'sh7FFF_FFFF;
                end
                d = longint'($urandom_range(0, 32'(span)));
                if ($urandom_range(0, 1))
                begin
                    d = -d;
                end
                return 32'(longint'(offset_q) + d);
            end
        endcase
    endfunction

    task automatic test_random_sweep();
        int phase;
        int k;
        for (phase = 0; phase < 13; phase++)
        begin
            settle();
            steady_flow = (phase % 4 == 2);
            write_register(CFG_AMPLITUDE, pick_amplitude());
            write_register(CFG_RATE, pick_rate());
            if ($urandom_range(0, 3) == 0)
            begin
                write_register(CFG_OFFSET, $urandom);
            end
            else
            begin
                write_register(CFG_OFFSET, signed_span(32'h0040_0000));
            end
            for (k = 0; k < 106; k++)
            begin
                send_x(pick_x());
            end
        end
        settle();
        steady_flow = 1'b0;
    endtask

    initial
    begin
        build_exp2_table();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_default_response();
        test_zero_amplitude();
        test_negative_tail();
        test_register_extremes();
        test_unused_index();
        test_random_sweep();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && expected_damping.size() == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
